// ===== rtl/glyph_framebuffer_renderer_defines.svh =====
// ----------------------------------------------------------------------------
// Glyph framebuffer renderer: shared assertion macros
// Concurrent checks with a common clock and reset guard.
// ----------------------------------------------------------------------------
`ifndef GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH
`define GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH

// Same-cycle implication
`define GFR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph renderer: same-cycle check failed");

// Next-cycle implication
`define GFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph renderer: next-cycle check failed");

`endif

// ===== rtl/gfr_pkg.sv =====
// ----------------------------------------------------------------------------
// gfr_pkg
// Types, constants and the 5x7 font for the glyph framebuffer renderer.
// ----------------------------------------------------------------------------
package gfr_pkg;

    // Default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    // Font geometry and code range
    localparam int FIRST_CODE = 32;
    localparam int LAST_CODE  = 126;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;

    // Command codes
    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_PIXEL = 3'd1;
    localparam logic [2:0] KIND_CHAR  = 3'd2;
    localparam logic [2:0] KIND_LARGE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_CAPT,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the accepted item
        logic clr_step;  // write one zero byte of the clearing sweep
        logic step;      // one read-modify-write step of a draw
        logic rd_byte;   // issue the read_byte memory read
        logic capture;   // latch the read data into the result
        logic emit;      // move the result into the output register
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] kind;      // kind of the item on offer
        logic       large_ok;  // its code lies in the font range
        logic       last_step; // current draw step is the final one
        logic       clr_last;  // sweep is at the final byte
        logic       out_free;  // output register can take a result
    } stat_t;

    // Five font columns, leftmost in the top byte; bit r is row r.
    // Codes outside the font give the '?' glyph.
    function automatic logic [39:0] glyph_bits(input logic [7:0] code);
        logic [39:0] g;
        case (code)
            8'd32:  g = 40'h0000000000;
            8'd33:  g = 40'h00005F0000;
            8'd34:  g = 40'h0007000700;
            8'd35:  g = 40'h147F147F14;
            8'd36:  g = 40'h242A7F2A12;
            8'd37:  g = 40'h2313086462;
            8'd38:  g = 40'h3649562050;
            8'd39:  g = 40'h0008070300;
            8'd40:  g = 40'h001C224100;
            8'd41:  g = 40'h0041221C00;
            8'd42:  g = 40'h2A1C7F1C2A;
            8'd43:  g = 40'h08083E0808;
            8'd44:  g = 40'h0080703000;
            8'd45:  g = 40'h0808080808;
            8'd46:  g = 40'h0000606000;
            8'd47:  g = 40'h2010080402;
            8'd48:  g = 40'h3E5149453E;
            8'd49:  g = 40'h00427F4000;
            8'd50:  g = 40'h7249494946;
            8'd51:  g = 40'h2141494D33;
            8'd52:  g = 40'h1814127F10;
            8'd53:  g = 40'h2745454539;
            8'd54:  g = 40'h3C4A494931;
            8'd55:  g = 40'h4121110907;
            8'd56:  g = 40'h3649494936;
            8'd57:  g = 40'h464949291E;
            8'd58:  g = 40'h0000140000;
            8'd59:  g = 40'h0040340000;
            8'd60:  g = 40'h0008142241;
            8'd61:  g = 40'h1414141414;
            8'd62:  g = 40'h0041221408;
            8'd63:  g = 40'h0201590906;
            8'd64:  g = 40'h3E415D594E;
            8'd65:  g = 40'h7C1211127C;
            8'd66:  g = 40'h7F49494936;
            8'd67:  g = 40'h3E41414122;
            8'd68:  g = 40'h7F4141413E;
            8'd69:  g = 40'h7F49494941;
            8'd70:  g = 40'h7F09090901;
            8'd71:  g = 40'h3E41415173;
            8'd72:  g = 40'h7F0808087F;
            8'd73:  g = 40'h00417F4100;
            8'd74:  g = 40'h2040413F01;
            8'd75:  g = 40'h7F08142241;
            8'd76:  g = 40'h7F40404040;
            8'd77:  g = 40'h7F021C027F;
            8'd78:  g = 40'h7F0408107F;
            8'd79:  g = 40'h3E4141413E;
            8'd80:  g = 40'h7F09090906;
            8'd81:  g = 40'h3E4151215E;
            8'd82:  g = 40'h7F09192946;
            8'd83:  g = 40'h2649494932;
            8'd84:  g = 40'h03017F0103;
            8'd85:  g = 40'h3F4040403F;
            8'd86:  g = 40'h1F2040201F;
            8'd87:  g = 40'h3F4038403F;
            8'd88:  g = 40'h6314081463;
            8'd89:  g = 40'h0304780403;
            8'd90:  g = 40'h6159494D43;
            8'd91:  g = 40'h007F414141;
            8'd92:  g = 40'h0204081020;
            8'd93:  g = 40'h004141417F;
            8'd94:  g = 40'h0402010204;
            8'd95:  g = 40'h4040404040;
            8'd96:  g = 40'h0003070800;
            8'd97:  g = 40'h2054547840;
            8'd98:  g = 40'h7F28444438;
            8'd99:  g = 40'h3844444428;
            8'd100: g = 40'h384444287F;
            8'd101: g = 40'h3854545418;
            8'd102: g = 40'h00087E0902;
            8'd103: g = 40'h18A4A49C78;
            8'd104: g = 40'h7F08040478;
            8'd105: g = 40'h00447D4000;
            8'd106: g = 40'h2040403D00;
            8'd107: g = 40'h7F10284400;
            8'd108: g = 40'h00417F4000;
            8'd109: g = 40'h7C04780478;
            8'd110: g = 40'h7C08040478;
            8'd111: g = 40'h3844444438;
            8'd112: g = 40'hFC18242418;
            8'd113: g = 40'h18242418FC;
            8'd114: g = 40'h7C08040408;
            8'd115: g = 40'h4854545424;
            8'd116: g = 40'h04043F4424;
            8'd117: g = 40'h3C4040207C;
            8'd118: g = 40'h1C2040201C;
            8'd119: g = 40'h3C4030403C;
            8'd120: g = 40'h4428102844;
            8'd121: g = 40'h4C9090907C;
            8'd122: g = 40'h4464544C44;
            8'd123: g = 40'h0008364100;
            8'd124: g = 40'h0000770000;
            8'd125: g = 40'h0041360800;
            8'd126: g = 40'h0201020402;
            default: g = 40'h0201590906;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/gfr_in_if.sv =====
// ----------------------------------------------------------------------------
// gfr_in_if
// Command channel: valid/ready handshake with the draw command payload.
// ----------------------------------------------------------------------------
interface gfr_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic              pixel_on;
    logic [7:0]        char_code;
    logic [9:0]        byte_index;

    modport source (
        output valid, kind, pos_x, pos_y, pixel_on, char_code, byte_index,
        input  ready
    );

    modport sink (
        input  valid, kind, pos_x, pos_y, pixel_on, char_code, byte_index,
        output ready
    );
endinterface

// ===== rtl/gfr_out_if.sv =====
// ----------------------------------------------------------------------------
// gfr_out_if
// Result channel: valid/ready handshake carrying one read_data byte.
// ----------------------------------------------------------------------------
interface gfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );

    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

// ===== rtl/gfr_ram.sv =====
// ----------------------------------------------------------------------------
// gfr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/gfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gfr_ctrl
// Command sequencer: accepts items, steps the datapath through clear,
// draw and read, and hands each result to the output register.
// ----------------------------------------------------------------------------
module gfr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gfr_pkg::stat_t stat,
    output gfr_pkg::ctl_t  ctl
);
    import gfr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   clr_cmd_reg;   // sweep was started by a clear item
    logic   clr_cmd_next;

    // State register; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cmd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        clr_cmd_next = clr_cmd_reg;
        ctl          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next   = clr_cmd_reg ? ST_DONE : ST_IDLE;
                    clr_cmd_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    case (stat.kind)
                        KIND_CLEAR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_cmd_next = 1'b1;
                        end
                        KIND_PIXEL: state_next = ST_DRAW;
                        KIND_CHAR:  state_next = ST_DRAW;
                        KIND_LARGE: state_next = stat.large_ok ? ST_DRAW : ST_DONE;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_DRAW:
            begin
                ctl.step = 1'b1;
                if (stat.last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                ctl.rd_byte = 1'b1;
                state_next  = ST_CAPT;
            end
            ST_CAPT:
            begin
                ctl.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gfr_datapath.sv =====
// ----------------------------------------------------------------------------
// gfr_datapath
// Frame store, item registers, page read-modify-write pipe, clearing sweep
// counter and the output register.
// ----------------------------------------------------------------------------
`include "glyph_framebuffer_renderer_defines.svh"

module gfr_datapath #(
    parameter int SCREEN_WIDTH  = gfr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = gfr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        kind,
    input  logic signed [9:0] pos_x,
    input  logic signed [9:0] pos_y,
    input  logic              pixel_on,
    input  logic [7:0]        char_code,
    input  logic [9:0]        byte_index,
    input  gfr_pkg::ctl_t     ctl,
    output gfr_pkg::stat_t    stat,
    gfr_out_if.source         rsp
);
    import gfr_pkg::*;

    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    // Item registers
    logic signed [9:0]             x_reg;
    logic signed [9:0]             y_reg;
    logic                          scale2_reg;
    logic [3:0]                    len_reg;        // rows covered: 1, 7 or 14
    logic [3:0]                    col_last_reg;
    logic [1:0]                    pg_last_reg;
    logic [GLYPH_COLS-1:0][7:0]    cols_reg;
    logic                          idx_ok_reg;
    logic [ADDR_W-1:0]             idx_reg;
    logic [7:0]                    res_reg;

    // Step counters and clearing sweep
    logic [3:0]                    col_reg;
    logic [1:0]                    pg_reg;
    logic [ADDR_W-1:0]             clr_reg;

    // Pending write stage
    logic                          wr_pend_reg;
    logic [ADDR_W-1:0]             wr_addr_reg;
    logic [7:0]                    wr_mask_reg;
    logic [7:0]                    wr_bits_reg;

    // Output register
    logic                          out_valid_reg;
    logic [7:0]                    out_data_reg;

    // Step logic
    logic signed [10:0]            x_pos;
    logic signed [7:0]             page_s;
    logic                          col_ok;
    logic                          page_ok;
    logic [2:0]                    gcol;
    logic [7:0]                    col_byte;
    logic [4:0]                    t_row;
    logic [4:0]                    e_row;
    logic [9:0]                    y_row;
    logic [7:0]                    step_mask;
    logic [7:0]                    step_bits;
    logic                          step_ok;
    logic [ADDR_W-1:0]             step_addr;
    logic                          step_last;
    logic [GLYPH_COLS-1:0][7:0]    cols_load;
    logic [39:0]                   glyph_word;

    // Memory ports
    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             ram_wr_addr;
    logic [7:0]                    ram_wr_data;
    logic                          ram_rd_en;
    logic [ADDR_W-1:0]             ram_rd_addr;
    logic [7:0]                    ram_rd_data;

    gfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Font lookup for the item on offer, columns split out
    always_comb
    begin
        glyph_word = glyph_bits(char_code);
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            cols_load[c] = glyph_word[8*(GLYPH_COLS-1-c) +: 8];
        end
    end

    // One page byte of one pixel column: address, mask and new bits
    always_comb
    begin
        x_pos    = $signed({x_reg[9], x_reg}) + $signed({7'b0, col_reg});
        page_s   = $signed({y_reg[9], y_reg[9:3]}) + $signed({6'b0, pg_reg});
        col_ok   = !x_pos[10] && ({1'b0, x_pos[9:0]} < 11'(SCREEN_WIDTH));
        page_ok  = !page_s[7] && (page_s[6:0] < 7'(PAGES));
        gcol     = scale2_reg ? col_reg[3:1] : col_reg[2:0];
        col_byte = cols_reg[gcol];
        t_row    = '0;
        e_row    = '0;
        y_row    = '0;
        for (int b = 0; b < 8; b++)
        begin
            // row offset of bit b from the glyph top
            t_row        = {pg_reg, 3'b000} + 5'(b);
            e_row        = t_row - {2'b00, y_reg[2:0]};
            y_row        = {page_s[6:0], 3'(b)};
            step_mask[b] = (t_row >= {2'b00, y_reg[2:0]}) && (e_row < {1'b0, len_reg})
                           && ({1'b0, y_row} < 11'(SCREEN_HEIGHT));
            step_bits[b] = scale2_reg ? col_byte[e_row[3:1]] : col_byte[e_row[2:0]];
        end
        step_ok   = col_ok && page_ok && (step_mask != 8'h00);
        step_addr = ADDR_W'(x_pos[9:0]) + ADDR_W'(page_s[6:0]) * ADDR_W'(SCREEN_WIDTH);
        step_last = (col_reg == col_last_reg) && (pg_reg == pg_last_reg);
    end

    // Memory port selection: sweep or merge on write, step or read_byte on read
    always_comb
    begin
        ram_wr_en   = ctl.clr_step || wr_pend_reg;
        ram_wr_addr = ctl.clr_step ? clr_reg : wr_addr_reg;
        ram_wr_data = ctl.clr_step ? 8'h00
                    : (ram_rd_data & ~wr_mask_reg) | (wr_bits_reg & wr_mask_reg);
        ram_rd_en   = (ctl.step && step_ok) || (ctl.rd_byte && idx_ok_reg);
        ram_rd_addr = ctl.rd_byte ? idx_reg : step_addr;
    end

    // Item capture, result latch
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg      <= pos_x;
            y_reg      <= pos_y;
            idx_ok_reg <= int'(byte_index) < STORE_BYTES;
            idx_reg    <= ADDR_W'(byte_index);
            res_reg    <= 8'h00;
            case (kind)
                KIND_PIXEL:
                begin
                    scale2_reg   <= 1'b0;
                    len_reg      <= 4'd1;
                    col_last_reg <= 4'd0;
                    pg_last_reg  <= 2'd0;
                    cols_reg     <= {GLYPH_COLS{{8{pixel_on}}}};
                end
                KIND_LARGE:
                begin
                    scale2_reg   <= 1'b1;
                    len_reg      <= 4'(2 * GLYPH_ROWS);
                    col_last_reg <= 4'(2 * GLYPH_COLS - 1);
                    pg_last_reg  <= 2'd2;
                    cols_reg     <= cols_load;
                end
                default:
                begin
                    scale2_reg   <= 1'b0;
                    len_reg      <= 4'(GLYPH_ROWS);
                    col_last_reg <= 4'(GLYPH_COLS - 1);
                    pg_last_reg  <= 2'd1;
                    cols_reg     <= cols_load;
                end
            endcase
        end
        else if (ctl.capture)
        begin
            res_reg <= idx_ok_reg ? ram_rd_data : 8'h00;
        end
    end

    // Step counters: pages of a column first, then the next column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            pg_reg  <= '0;
        end
        else if (ctl.load)
        begin
            col_reg <= '0;
            pg_reg  <= '0;
        end
        else if (ctl.step)
        begin
            if (pg_reg == pg_last_reg)
            begin
                pg_reg  <= '0;
                col_reg <= col_reg + 4'd1;
            end
            else
            begin
                pg_reg <= pg_reg + 2'd1;
            end
        end
    end

    // Clearing sweep address, wraps back to zero at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clr_step)
        begin
            clr_reg <= stat.clr_last ? '0 : clr_reg + ADDR_W'(1);
        end
    end

    // Pending write: issued with the read, merged in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= ctl.step && step_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            wr_addr_reg <= step_addr;
            wr_mask_reg <= step_mask;
            wr_bits_reg <= step_bits;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    // Status to the controller
    always_comb
    begin
        stat.kind      = kind;
        stat.large_ok  = (char_code >= 8'(FIRST_CODE)) && (char_code <= 8'(LAST_CODE));
        stat.last_step = step_last;
        stat.clr_last  = (clr_reg == ADDR_W'(STORE_BYTES - 1));
        stat.out_free  = !out_valid_reg || rsp.ready;
    end

    // Checks
    `GFR_ASSERT_IMPLY(a_sweep_no_merge, clk, rst_n, ctl.clr_step, !wr_pend_reg)
    `GFR_ASSERT_IMPLY(a_no_out_overwrite, clk, rst_n, ctl.emit, !out_valid_reg || rsp.ready)
    `GFR_ASSERT_IMPLY(a_wr_in_store, clk, rst_n, wr_pend_reg, int'(wr_addr_reg) < STORE_BYTES)
    `GFR_ASSERT_NEXT(a_load_clears_steps, clk, rst_n, ctl.load, col_reg == 4'd0 && pg_reg == 2'd0)

endmodule

// ===== rtl/glyph_framebuffer_renderer.sv =====
// ----------------------------------------------------------------------------
// glyph_framebuffer_renderer
// Page-organised monochrome framebuffer with pixel, 5x7 text and 2x text
// drawing, clear and byte read-back; one result byte per command item.
// ----------------------------------------------------------------------------
//   channel | role   | handshake     | payload
//   cmd     | sink   | valid / ready | kind, pos_x, pos_y, pixel_on, char_code,
//           |        |               | byte_index
//   rsp     | source | valid / ready | read_data
//
// Draws run one page-byte read-modify-write per cycle through the frame
// store's single write port. After reset a clearing sweep over all
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes (1024 by default) runs before
// the first item is accepted; each item is finished before the next is taken.
// A result waits in the output register while the next item is taken; a
// further result holds the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module glyph_framebuffer_renderer #(
    parameter int SCREEN_WIDTH  = gfr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = gfr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    gfr_in_if.sink    cmd,
    gfr_out_if.source rsp
);
    import gfr_pkg::*;

    ctl_t ctl;
    stat_t stat;
    logic in_ready;

    assign cmd.ready = in_ready;

    gfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    gfr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (cmd.kind),
        .pos_x      (cmd.pos_x),
        .pos_y      (cmd.pos_y),
        .pixel_on   (cmd.pixel_on),
        .char_code  (cmd.char_code),
        .byte_index (cmd.byte_index),
        .ctl        (ctl),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule

// ===== tb/glyph_framebuffer_renderer_tb.sv =====
// ----------------------------------------------------------------------------
// glyph_framebuffer_renderer_tb
// Drives draw commands into the renderer and checks every read_data item
// against a shadow framebuffer kept in the bench. A directed opening covers
// screen edges, clipping, font fallback and unused kinds; random text runs,
// pixels, 2x glyphs and read-backs near recent drawing follow, with random
// idle bursts on both channels and a quiet tail.
// ----------------------------------------------------------------------------
module glyph_framebuffer_renderer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gfr_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int SCR_W          = SCREEN_WIDTH_DEF;
    localparam int SCR_H          = SCREEN_HEIGHT_DEF;
    localparam int STORE_SIZE     = SCR_W * ((SCR_H + 7) / 8);
    localparam int N_RANDOM       = 1775;
    localparam int N_TAIL         = 150;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 64;

    // Lowest of the kind codes the block ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    // Glyph drawn by the 1x command for codes outside the font
    localparam int QMARK_CODE = 63;

    // Five columns per glyph, code 32 in the top bits, leftmost column in
    // the top byte of each group; bit r is row r from the top.
    localparam logic [95*40-1:0] FONT_TABLE = {
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
        40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
        40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
        40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
        40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
        40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
        40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
        40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
        40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
        40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
        40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
        40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
        40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
        40'h0000770000, 40'h0041360800, 40'h0201020402
    };

    // One command item plus its pacing controls
    typedef struct packed {
        logic [2:0]        kind;
        logic signed [9:0] pos_x;
        logic signed [9:0] pos_y;
        logic              pixel_on;
        logic [7:0]        char_code;
        logic [9:0]        byte_index;
        logic [4:0]        gap;        // idle cycles before offering
        logic              wait_drain; // hold until all read_data is back
        logic              tail;       // part of the idle-free ending
    } draw_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    gfr_in_if  cmd_if ();
    gfr_out_if rsp_if ();

    glyph_framebuffer_renderer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    draw_cmd_t  pending_cmds[$];
    logic [7:0] expected_bytes[$];
    logic [7:0] shadow_fb [0:STORE_SIZE-1];

    draw_cmd_t  seen_cmd;
    logic [7:0] want_byte;
    logic       cmd_taken    = 1'b0;
    int         gap_left     = 0;
    logic       gap_served   = 1'b0;
    logic       quiet_tail   = 1'b0;
    int         stall_left   = 0;
    logic       stall_phase  = 1'b1;
    int         quiet_cycles = 0;
    int         mismatch_count = 0;

    task automatic flag_mismatch(input string msg);
        $display("ERROR [%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Shadow framebuffer
    // ------------------------------------------------------------------
    function automatic void wipe_frame();
        for (int a = 0; a < STORE_SIZE; a++)
            shadow_fb[a] = 8'h00;
    endfunction

    // Off-screen pixels are dropped one by one
    function automatic void plot(input int x, input int y, input logic on);
        if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
            return;
        shadow_fb[x + (y / 8) * SCR_W][y % 8] = on;
    endfunction

    // Writes both set and clear pixels of the whole cell; row 7 never drawn
    function automatic void stamp_glyph(input int x0, input int y0, input int code,
                                        input int scale);
        logic [39:0] glyph_cols;
        logic [7:0]  column;
        glyph_cols = FONT_TABLE[(LAST_CODE - code) * 40 +: 40];
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            column = glyph_cols[(GLYPH_COLS - 1 - c) * 8 +: 8];
            for (int r = 0; r < GLYPH_ROWS; r++)
                for (int dx = 0; dx < scale; dx++)
                    for (int dy = 0; dy < scale; dy++)
                        plot(x0 + c * scale + dx, y0 + r * scale + dy, column[r]);
        end
    endfunction

    // Applies one command to the shadow and returns its read_data
    function automatic logic [7:0] apply_command(input draw_cmd_t c);
        int         x;
        int         y;
        int         code;
        logic [7:0] data;
        x    = $signed(c.pos_x);
        y    = $signed(c.pos_y);
        code = c.char_code;
        data = 8'h00;
        case (c.kind)
            KIND_CLEAR: wipe_frame();
            KIND_PIXEL: plot(x, y, c.pixel_on);
            KIND_CHAR:
            begin
                if (code < FIRST_CODE || code > LAST_CODE)
                    code = QMARK_CODE;
                stamp_glyph(x, y, code, 1);
            end
            KIND_LARGE:
            begin
                // out-of-font codes draw nothing at 2x
                if (code >= FIRST_CODE && code <= LAST_CODE)
                    stamp_glyph(x, y, code, 2);
            end
            KIND_READ:
            begin
                if (c.byte_index < STORE_SIZE)
                    data = shadow_fb[c.byte_index];
            end
            default: ;
        endcase
        return data;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Every field random, so unused fields carry junk
    function automatic draw_cmd_t noise_cmd();
        draw_cmd_t c;
        c            = '0;
        c.kind       = 3'($urandom);
        c.pos_x      = 10'($urandom);
        c.pos_y      = 10'($urandom);
        c.pixel_on   = 1'($urandom);
        c.char_code  = 8'($urandom);
        c.byte_index = 10'($urandom);
        return c;
    endfunction

    function automatic draw_cmd_t make_cmd(input logic [2:0] k, input int x, input int y,
                                           input logic on, input int code, input int idx);
        draw_cmd_t c;
        c      = noise_cmd();
        c.kind = k;
        case (k)
            KIND_PIXEL:
            begin
                c.pos_x    = 10'(x);
                c.pos_y    = 10'(y);
                c.pixel_on = on;
            end
            KIND_CHAR, KIND_LARGE:
            begin
                c.pos_x     = 10'(x);
                c.pos_y     = 10'(y);
                c.char_code = 8'(code);
            end
            KIND_READ: c.byte_index = 10'(idx);
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: changes inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && !cmd_taken)
            begin
                // item still on offer
            end
            else if (gap_left != 0)
            begin
                gap_left     <= gap_left - 1;
                cmd_if.valid <= 1'b0;
            end
            else if (pending_cmds.size() == 0)
            begin
                cmd_if.valid <= 1'b0;
            end
            else if (pending_cmds[0].gap != 0 && !gap_served)
            begin
                gap_left     <= pending_cmds[0].gap - 1;
                gap_served   <= 1'b1;
                cmd_if.valid <= 1'b0;
            end
            else if (pending_cmds[0].wait_drain && expected_bytes.size() != 0)
            begin
                cmd_if.valid <= 1'b0;
            end
            else
            begin
                seen_cmd          = pending_cmds.pop_front();
                cmd_if.kind       <= seen_cmd.kind;
                cmd_if.pos_x      <= seen_cmd.pos_x;
                cmd_if.pos_y      <= seen_cmd.pos_y;
                cmd_if.pixel_on   <= seen_cmd.pixel_on;
                cmd_if.char_code  <= seen_cmd.char_code;
                cmd_if.byte_index <= seen_cmd.byte_index;
                cmd_if.valid      <= 1'b1;
                gap_served        <= 1'b0;
                if (seen_cmd.tail)
                    quiet_tail <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall bursts in random stretches, none in the tail
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (!quiet_tail && stall_phase && $urandom_range(0, 5) == 0)
            begin
                stall_left   <= $urandom_range(0, 18);
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
            if ($urandom_range(0, 299) == 0)
                stall_phase <= !stall_phase;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            wipe_frame();
            cmd_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            // a result belongs to an earlier item, so check before predicting
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    flag_mismatch($sformatf("read_data %02h with no command outstanding",
                                            rsp_if.read_data));
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (rsp_if.read_data !== want_byte)
                        flag_mismatch($sformatf("read_data %02h, expected %02h",
                                                rsp_if.read_data, want_byte));
                end
            end
            if (cmd_if.valid && cmd_if.ready)
            begin
                seen_cmd            = '0;
                seen_cmd.kind       = cmd_if.kind;
                seen_cmd.pos_x      = cmd_if.pos_x;
                seen_cmd.pos_y      = cmd_if.pos_y;
                seen_cmd.pixel_on   = cmd_if.pixel_on;
                seen_cmd.char_code  = cmd_if.char_code;
                seen_cmd.byte_index = cmd_if.byte_index;
                expected_bytes.push_back(apply_command(seen_cmd));
            end
            cmd_taken <= cmd_if.valid && cmd_if.ready;

            // watchdog on cycles without any handshake
            if ((rsp_if.valid && rsp_if.ready) || (cmd_if.valid && cmd_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset, stimulus list and end of run
    // ------------------------------------------------------------------
    initial
    begin
        draw_cmd_t it;
        int        roll;
        int        px;
        int        py;
        int        code;
        int        idx;
        int        text_x;
        int        text_y;
        int        anchor_x;
        int        anchor_y;

        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.kind       = KIND_CLEAR;
        cmd_if.pos_x      = '0;
        cmd_if.pos_y      = '0;
        cmd_if.pixel_on   = 1'b0;
        cmd_if.char_code  = '0;
        cmd_if.byte_index = '0;
        rsp_if.ready      = 1'b0;

        // Directed: buffer corners, off-screen pixels, font fallback,
        // clipped glyphs at both scales, unused kinds, clear
        pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, STORE_SIZE - 1));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, 0, 0, 1, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, SCR_W - 1, SCR_H - 1, 1, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, -1, 0, 1, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, SCR_W, SCR_H - 1, 1, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, 0, SCR_H, 1, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, -512, -512, 1, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, 511, 511, 1, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, STORE_SIZE - 1));
        pending_cmds.push_back(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_CHAR, 6, 8, 0, 65, 0));     // 'A'
        pending_cmds.push_back(make_cmd(KIND_CHAR, 12, 8, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_CHAR, 18, 8, 0, 255, 0));
        pending_cmds.push_back(make_cmd(KIND_CHAR, SCR_W - 3, SCR_H - 4, 0, LAST_CODE, 0));
        pending_cmds.push_back(make_cmd(KIND_CHAR, -2, -3, 0, 103, 0));  // 'g', bit 7 set
        it = make_cmd(KIND_LARGE, 30, 20, 0, 87, 0);                     // 'W'
        it.wait_drain = 1'b1;
        pending_cmds.push_back(it);
        pending_cmds.push_back(make_cmd(KIND_LARGE, 0, 0, 0, FIRST_CODE - 1, 0));
        pending_cmds.push_back(make_cmd(KIND_LARGE, 0, 0, 0, LAST_CODE + 1, 0));
        pending_cmds.push_back(make_cmd(KIND_LARGE, SCR_W - 7, SCR_H - 9, 0, 64, 0));
        pending_cmds.push_back(make_cmd(KIND_LARGE, -5, -9, 0, 121, 0));
        pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 6 + SCR_W));
        pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 30 + 2 * SCR_W));
        it = noise_cmd();
        it.kind = KIND_SPARE_LO;
        pending_cmds.push_back(it);
        pending_cmds.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0));

        // Random: text runs, pixels, 2x glyphs, reads mostly near recent drawing
        text_x   = SCR_W;
        text_y   = 0;
        anchor_x = 0;
        anchor_y = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            roll = $urandom_range(0, 999);
            if (roll < 12)
            begin
                it = make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0);
            end
            else if (roll < 40)
            begin
                it = noise_cmd();
                it.kind = KIND_SPARE_LO + 3'($urandom_range(0, 2));
            end
            else if (roll < 330)
            begin
                px = int'($urandom_range(0, SCR_W + 23)) - 12;
                py = int'($urandom_range(0, SCR_H + 23)) - 12;
                it = make_cmd(KIND_PIXEL, px, py, $urandom_range(0, 9) < 6, 0, 0);
                anchor_x = px - 4;
                anchor_y = py - 6;
            end
            else if (roll < 670)
            begin
                code = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 255))
                                                   : int'($urandom_range(FIRST_CODE, LAST_CODE));
                if (roll < 560)
                begin
                    // host-style string walk, six columns per glyph
                    text_x += 6;
                    if (text_x > SCR_W || $urandom_range(0, 15) == 0)
                    begin
                        text_x = int'($urandom_range(0, 12)) - 8;
                        text_y = int'($urandom_range(0, SCR_H + 8)) - 8;
                    end
                    px = text_x;
                    py = text_y;
                    it = make_cmd(KIND_CHAR, px, py, 0, code, 0);
                end
                else
                begin
                    px = int'($urandom_range(0, SCR_W + 19)) - 14;
                    py = int'($urandom_range(0, SCR_H + 27)) - 18;
                    it = make_cmd(KIND_LARGE, px, py, 0, code, 0);
                end
                anchor_x = px;
                anchor_y = py;
            end
            else
            begin
                idx = $urandom_range(0, STORE_SIZE - 1);
                if ($urandom_range(0, 3) != 0)
                begin
                    px = anchor_x + int'($urandom_range(0, 11));
                    py = anchor_y + int'($urandom_range(0, 15));
                    if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H)
                        idx = px + (py / 8) * SCR_W;
                end
                it = make_cmd(KIND_READ, 0, 0, 0, 0, idx);
            end

            // occasional coordinates anywhere in the 10-bit range
            if ((it.kind == KIND_PIXEL || it.kind == KIND_CHAR || it.kind == KIND_LARGE)
                && $urandom_range(0, 11) == 0)
            begin
                it.pos_x = 10'($urandom);
                it.pos_y = 10'($urandom);
            end

            if (i >= N_RANDOM - N_TAIL)
                it.tail = 1'b1;
            else if ((i / 160) % 4 != 3 && $urandom_range(0, 4) == 0)
                it.gap = 5'($urandom_range(1, 19));
            if (i % 300 == 0)
                it.wait_drain = 1'b1;
            pending_cmds.push_back(it);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all items taken, all results back, then a settling window
        while (pending_cmds.size() != 0 || cmd_if.valid)
            @(negedge clk);
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gfr_pkg.sv
rtl/gfr_in_if.sv
rtl/gfr_out_if.sv
rtl/gfr_ram.sv
rtl/gfr_ctrl.sv
rtl/gfr_datapath.sv
rtl/glyph_framebuffer_renderer.sv
tb/glyph_framebuffer_renderer_tb.sv
